// ===== rtl/stt_pkg.sv =====
package stt_pkg;

    // default table depth
    localparam int ENTRIES_DEFAULT = 64;

    // fixed field widths
    localparam int FUNC_W   = 2;
    localparam int TAG_W    = 64;
    localparam int KEY_W    = 40;
    localparam int HANDLE_W = 16;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_ORDER    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    // one stored task record
    typedef struct packed {
        logic [TAG_W-1:0]    name_tag;
        logic [KEY_W-1:0]    start_key;
        logic [KEY_W-1:0]    end_key;
        logic [HANDLE_W-1:0] desc_handle;
    } stt_entry_t;

endpackage

// ===== rtl/sorted_task_table.sv =====
// Sorted task table: up to ENTRIES task records kept in ascending start_key
// order in one synchronous single-port-write, single-port-read memory. A
// transaction is taken when start is high and busy is low; its result shows
// on the result ports for exactly one cycle with done high, and the receiver
// cannot hold it off, so it must capture the result in that cycle. A rejected
// insert, an empty read, a delete on an empty table and the unused operation
// code finish straight from S_IDLE, raising done in the cycle after start. A
// read returns the registered memory data in S_RD_WAIT. An insert moves each
// entry with a greater start_key up one place in S_INS_CMP, then writes the
// new record in the freed slot. A delete scans in S_DEL_SCAN up to the match,
// then moves each entry above it down in S_DEL_SHIFT; with no match the scan
// covers every entry. The memory moves one record per cycle. After reset the
// table is empty and ready at once; no clearing pass is needed.
module sorted_task_table
    import stt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [TAG_W-1:0]    name_tag,
    input  logic [KEY_W-1:0]    start_key,
    input  logic [KEY_W-1:0]    end_key,
    input  logic [HANDLE_W-1:0] desc_handle,
    input  logic [POS_W-1:0]    position,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  count,
    output logic [TAG_W-1:0]    out_name_tag,
    output logic [KEY_W-1:0]    out_start_key,
    output logic [KEY_W-1:0]    out_end_key,
    output logic [HANDLE_W-1:0] out_desc_handle
);

    localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_INS_CMP   = 6'b000010,
        S_INS_PUT   = 6'b000100,
        S_RD_WAIT   = 6'b001000,
        S_DEL_SCAN  = 6'b010000,
        S_DEL_SHIFT = 6'b100000
    } state_t;

    // record storage
    stt_entry_t mem [ENTRIES];
    stt_entry_t rd_data_reg;
    logic       wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    stt_entry_t wr_data;

    // control state
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          done_reg, done_next;

    // transaction payload and result registers
    stt_entry_t    new_reg, new_next;
    status_t       status_reg, status_next;
    stt_entry_t    out_reg, out_next;

    stt_entry_t    in_entry;
    logic [CW-1:0] ptr_inc;
    logic [CW-1:0] ptr_inc2;
    logic [CW-1:0] ptr_dec;

    assign in_entry.name_tag    = name_tag;
    assign in_entry.start_key   = start_key;
    assign in_entry.end_key     = end_key;
    assign in_entry.desc_handle = desc_handle;

    assign ptr_inc  = ptr_reg + CW'(1);
    assign ptr_inc2 = ptr_reg + CW'(2);
    assign ptr_dec  = ptr_reg - CW'(1);

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        done_next   = 1'b0;
        new_next    = new_reg;
        status_next = status_reg;
        out_next    = out_reg;
        wr_en       = 1'b0;
        wr_addr     = AW'(ptr_reg);
        wr_data     = new_reg;
        rd_addr     = AW'(ptr_inc);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    new_next = in_entry;
                    out_next = '0;
                    case (func_t'(func))
                        FUNC_INSERT:
                        begin
                            if (end_key <= start_key)
                            begin
                                status_next = ST_ORDER;
                                done_next   = 1'b1;
                            end
                            else if (count_reg == CW'(ENTRIES))
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                ptr_next   = '0;
                                state_next = S_INS_PUT;
                            end
                            else
                            begin
                                // fetch the last entry to compare first
                                ptr_next   = count_reg;
                                rd_addr    = AW'(count_reg - CW'(1));
                                state_next = S_INS_CMP;
                            end
                        end
                        FUNC_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOTFOUND;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                rd_addr    = '0;
                                state_next = S_DEL_SCAN;
                            end
                        end
                        FUNC_READ:
                        begin
                            if (CMPW'(position) < CMPW'(count_reg))
                            begin
                                rd_addr    = AW'(position);
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end

            // read data is the entry just below the free slot
            S_INS_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(ptr_reg);
                if (rd_data_reg.start_key > new_reg.start_key)
                begin
                    wr_data  = rd_data_reg;
                    ptr_next = ptr_dec;
                    rd_addr  = AW'(ptr_reg - CW'(2));
                    if (ptr_reg == CW'(1))
                    begin
                        state_next = S_INS_PUT;
                    end
                end
                else
                begin
                    wr_data     = new_reg;
                    count_next  = count_reg + CW'(1);
                    status_next = ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            // new record lands at the bottom of the table
            S_INS_PUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = AW'(ptr_reg);
                wr_data     = new_reg;
                count_next  = count_reg + CW'(1);
                status_next = ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            S_RD_WAIT:
            begin
                out_next    = rd_data_reg;
                status_next = ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            // read data is the entry at ptr, next entry already requested
            S_DEL_SCAN:
            begin
                rd_addr = AW'(ptr_inc);
                if (rd_data_reg.name_tag == new_reg.name_tag)
                begin
                    if (ptr_inc < count_reg)
                    begin
                        state_next = S_DEL_SHIFT;
                    end
                    else
                    begin
                        count_next  = count_reg - CW'(1);
                        status_next = ST_OK;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (ptr_inc < count_reg)
                begin
                    ptr_next = ptr_inc;
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            // read data is the entry above ptr, moved down one place
            S_DEL_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_addr  = AW'(ptr_reg);
                wr_data  = rd_data_reg;
                rd_addr  = AW'(ptr_inc2);
                ptr_next = ptr_inc;
                if (ptr_inc2 >= count_reg)
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        new_reg    <= new_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    // ports
    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign count           = COUNT_W'(count_reg);
    assign out_name_tag    = out_reg.name_tag;
    assign out_start_key   = out_reg.start_key;
    assign out_end_key     = out_reg.end_key;
    assign out_desc_handle = out_reg.desc_handle;

endmodule
